### rtl/ttcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcd_pkg
// shared types and constants of the ternary search tree dictionary
// ----------------------------------------------------------------------------
package ttcd_pkg;

	localparam int NODE_COUNT_DEF = 4096;

	localparam logic [1:0] OP_RESET  = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_INSERT = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] DIR_LT = 2'd0;
	localparam logic [1:0] DIR_EQ = 2'd1;
	localparam logic [1:0] DIR_GT = 2'd2;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SLOT  = 6'b000010,
		ST_RDREQ = 6'b000100,
		ST_CMP   = 6'b001000,
		ST_ALLOC = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

endpackage

### rtl/ttcd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcd_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ttcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/ternary_trie_cursor_dictionary_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_trie_cursor_dictionary_top
// ternary search tree dictionary with a walking cursor
// ----------------------------------------------------------------------------
// one transaction in on s_axis (operation, key, value), one out on m_axis.
// a small sequencer walks the node memory one node at a time: issue the
// read, then compare the key with one shared comparator and pick a link.
// a lookup ends on a match or on an empty link; an insert ends with the
// parent link patch and then the node write. a new input is taken only
// once the result transaction has completed, so the walk depth sets the
// rate. s_axis_tready is low while an item is worked on and while its
// result waits; a stalled receiver simply holds the result.
// after reset the tree is empty, the cursor sits at the root slot and the
// lookup counter is zero; no clearing pass is needed, nodes are written
// in full when allocated.
// ----------------------------------------------------------------------------
module ternary_trie_cursor_dictionary_top #(
	parameter int NODE_COUNT = ttcd_pkg::NODE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // operation[1:0], key[9:2], value[25:10]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata   // found, result_value, lookup_count, pool_full, cursor_empty
);
	localparam int AW = $clog2(NODE_COUNT);
	localparam int LW = AW + 1;          // link incl. null marker bit
	localparam logic [LW-1:0] NIL = {1'b1, {AW{1'b0}}};
	localparam logic [AW:0] POOL_END = LW'(NODE_COUNT);

	ttcd_pkg::state_t state_q;
	logic [1:0]    op_q, dir_q, cdir_q;
	logic [7:0]    key_q;
	logic [15:0]   val_q;
	logic [LW-1:0] p_q, sn_q, cnode_q, root_q;
	logic [AW:0]   used_q;
	logic [31:0]   cnt_q;
	logic          found_q, full_q, empty_q;
	logic [15:0]   rv_q;

	// memory: key, value, lt/eq/gt links
	logic          we;
	logic [AW-1:0] addr;
	logic [8+16+3*LW-1:0] wd, rd;
	logic [7:0]    rkey;
	logic [15:0]   rval;
	logic [LW-1:0] rl [3];

	assign rkey  = rd[7:0];
	assign rval  = rd[23:8];
	assign rl[0] = rd[24 +: LW];
	assign rl[1] = rd[24+LW +: LW];
	assign rl[2] = rd[24+2*LW +: LW];

	ttcd_ram #(.WIDTH(8+16+3*LW), .DEPTH(NODE_COUNT)) u_nodes (
		.clk(clk), .we(we), .addr(addr), .wdata(wd), .rdata(rd)
	);

	logic pool_out;
	assign pool_out = (used_q == POOL_END);

	logic link_wr;   // patch a link of node sn_q
	assign link_wr = (state_q == ttcd_pkg::ST_ALLOC) && !sn_q[AW];

	always_comb begin
		we = 1'b0;
		addr = p_q[AW-1:0];
		wd = rd;
		if (state_q == ttcd_pkg::ST_IDLE) begin
			// fetch the cursor owner node for the slot lookup
			addr = cnode_q[AW-1:0];
		end else if (state_q == ttcd_pkg::ST_RDREQ && p_q[AW]) begin
			// walk ended on an empty link: fetch the parent for the patch
			addr = sn_q[AW-1:0];
		end else if (link_wr && !pool_out) begin
			// read-modify-write of the parent link; rd holds the parent
			we = 1'b1;
			addr = sn_q[AW-1:0];
			case (dir_q)
				ttcd_pkg::DIR_LT: wd[24 +: LW] = {1'b0, used_q[AW-1:0]};
				ttcd_pkg::DIR_EQ: wd[24+LW +: LW] = {1'b0, used_q[AW-1:0]};
				default:          wd[24+2*LW +: LW] = {1'b0, used_q[AW-1:0]};
			endcase
		end else if (state_q == ttcd_pkg::ST_DONE && op_q == ttcd_pkg::OP_INSERT
				&& !full_q) begin
			// new node, p_q holds its index
			we = 1'b1;
			wd = {NIL, NIL, NIL, val_q, key_q};
		end
	end

	logic [1:0] cmp_dir;
	always_comb begin
		if (key_q < rkey) cmp_dir = ttcd_pkg::DIR_LT;
		else if (key_q > rkey) cmp_dir = ttcd_pkg::DIR_GT;
		else cmp_dir = ttcd_pkg::DIR_EQ;
	end

	logic [LW-1:0] slot_val;
	assign slot_val = cnode_q[AW] ? root_q : rl[cdir_q];

	assign s_axis_tready = (state_q == ttcd_pkg::ST_IDLE) && !m_axis_tvalid;
	assign m_axis_tdata = {5'd0, empty_q, full_q, cnt_q, rv_q, found_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttcd_pkg::ST_IDLE;
			m_axis_tvalid <= 1'b0;
			used_q <= '0;
			root_q <= NIL;
			cnode_q <= NIL;
			cdir_q <= ttcd_pkg::DIR_LT;
			cnt_q <= '0;
			found_q <= 1'b0;
			rv_q <= '0;
			full_q <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (state_q)
				ttcd_pkg::ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						op_q <= s_axis_tdata[1:0];
						key_q <= s_axis_tdata[9:2];
						val_q <= s_axis_tdata[25:10];
						found_q <= 1'b0; rv_q <= '0; full_q <= 1'b0; empty_q <= 1'b0;
						sn_q <= cnode_q;
						dir_q <= cdir_q;
						p_q <= cnode_q;
						state_q <= ttcd_pkg::ST_SLOT;
						if (s_axis_tdata[1:0] == ttcd_pkg::OP_LOOKUP) cnt_q <= cnt_q + 32'd1;
					end
				end
				ttcd_pkg::ST_SLOT: begin
					// rd holds cursor owner node now
					p_q <= slot_val;
					state_q <= ttcd_pkg::ST_RDREQ;
					case (op_q)
						ttcd_pkg::OP_RESET: begin
							cnode_q <= NIL;
							cdir_q <= ttcd_pkg::DIR_LT;
							state_q <= ttcd_pkg::ST_DONE;
						end
						ttcd_pkg::OP_READ: begin
							if (slot_val[AW]) begin
								empty_q <= 1'b1;
								state_q <= ttcd_pkg::ST_DONE;
							end
						end
						default: ;
					endcase
				end
				ttcd_pkg::ST_RDREQ: begin
					if (p_q[AW]) state_q <= ttcd_pkg::ST_ALLOC;
					else state_q <= ttcd_pkg::ST_CMP;
					if (p_q[AW] && op_q != ttcd_pkg::OP_INSERT) state_q <= ttcd_pkg::ST_DONE;
				end
				ttcd_pkg::ST_CMP: begin
					if (op_q == ttcd_pkg::OP_READ) begin
						found_q <= 1'b1;
						rv_q <= rval;
						state_q <= ttcd_pkg::ST_DONE;
					end else if (op_q == ttcd_pkg::OP_LOOKUP) begin
						cnode_q <= p_q;
						cdir_q <= cmp_dir;
						if (cmp_dir == ttcd_pkg::DIR_EQ) begin
							found_q <= 1'b1;
							rv_q <= rval;
							state_q <= ttcd_pkg::ST_DONE;
						end else begin
							p_q <= rl[cmp_dir];
							state_q <= ttcd_pkg::ST_RDREQ;
						end
					end else begin
						sn_q <= p_q;
						dir_q <= cmp_dir;
						p_q <= rl[cmp_dir];
						state_q <= ttcd_pkg::ST_RDREQ;
					end
				end
				ttcd_pkg::ST_ALLOC: begin
					if (pool_out) begin
						full_q <= 1'b1;
					end else begin
						p_q <= {1'b0, used_q[AW-1:0]};
						used_q <= used_q + LW'(1);
						if (sn_q[AW]) root_q <= {1'b0, used_q[AW-1:0]};
					end
					state_q <= ttcd_pkg::ST_DONE;
				end
				ttcd_pkg::ST_DONE: begin
					m_axis_tvalid <= 1'b1;
					state_q <= ttcd_pkg::ST_IDLE;
				end
				default: state_q <= ttcd_pkg::ST_IDLE;
			endcase
		end
	end

	// the parent is read in RDREQ once the walk hits an empty link, its link
	// is patched in ALLOC and the new node itself is written in DONE

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= POOL_END)
		else $error("node count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(full_q && found_q))
		else $error("full and found together");
	assert property (@(posedge clk) disable iff (!arst_n)
		link_wr |-> op_q == ttcd_pkg::OP_INSERT)
		else $error("link patch outside insert");
endmodule
